// File: design/throughput_boost_level_selector_core_defines.svh
// Assertion macros for the boost level selector core.
`ifndef THROUGHPUT_BOOST_LEVEL_SELECTOR_CORE_DEFINES_SVH
`define THROUGHPUT_BOOST_LEVEL_SELECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TBLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("boost level selector: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("boost level selector: next-cycle check failed");

`else

`define TBLS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TBLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/tbls_pkg.sv
// Constants, codes and types shared by the boost level selector core.
package tbls_pkg;

    // Table geometry.
    localparam int DEVICES   = 4;
    localparam int LEVELS    = 8;
    localparam int ITEMS     = 12;
    localparam int DEV_W     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_W     = $clog2(LEVELS + 1);
    localparam int ITEM_W    = 4;
    localparam int NL_W      = 4;
    localparam int MEM_AW    = DEV_W + LVL_W + ITEM_W;
    localparam int MEM_DEPTH = DEVICES << (LVL_W + ITEM_W);

    // A level in force, minus one when the device holds none.
    typedef logic signed [NL_W-1:0] t_level;
    localparam t_level LEVEL_NONE = -4'sd1;

    // Input kinds.
    localparam logic [2:0] KIND_REPORT    = 3'd0;
    localparam logic [2:0] KIND_TABLE     = 3'd1;
    localparam logic [2:0] KIND_COUNT     = 3'd2;
    localparam logic [2:0] KIND_BLOCK_ON  = 3'd3;
    localparam logic [2:0] KIND_BLOCK_OFF = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_REJECTED  = 3'd0;
    localparam logic [2:0] ST_UNCHANGED = 3'd1;
    localparam logic [2:0] ST_RELEASED  = 3'd2;
    localparam logic [2:0] ST_APPLIED   = 3'd3;
    localparam logic [2:0] ST_SETUP     = 3'd4;

    // Table item indexes.
    localparam logic [ITEM_W-1:0] ITEM_THRESH = 4'd0;
    localparam logic [ITEM_W-1:0] ITEM_FIRST  = 4'd1;
    localparam logic [ITEM_W-1:0] ITEM_LAST   = 4'd11;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DECIDE,
        S_APPLY
    } t_state;

endpackage

// File: design/throughput_boost_level_selector_core.sv
// Boost level selector core: one transaction in, one or eleven result transactions out.
// Setup, block, rejected and blocked-device report results register from the execute state.
// A speed report reads one threshold a cycle, then issues one applied item a cycle while the
// result stream is not stalled.
// Throughput: a new transaction is taken once the previous one has issued its final result.
// Reset (synchronous, active low) clears counts, block flags, mask and levels, not the table.
`include "throughput_boost_level_selector_core_defines.svh"

module throughput_boost_level_selector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: slowdown_mask.
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // device_code[3:0], speed_mbps[31:4], level_index[34:32], item_index[38:35],
    // item_value[70:39], zero pad[71]
    input  logic [71:0] i_s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // new_level[3:0], out_item_index[7:4], out_item_value[39:8]
    output logic [39:0] o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    // ------------------------------------------------------------------
    // Declarations.
    // ------------------------------------------------------------------
    tbls_pkg::t_state r_state, n_state;

    logic [3:0]  r_mask;
    logic [tbls_pkg::CNT_W-1:0] r_cnt [tbls_pkg::DEVICES];
    tbls_pkg::t_level r_cur [tbls_pkg::DEVICES];
    logic        r_blk [tbls_pkg::DEVICES];

    // Latched input transaction.
    logic [2:0]  r_kind;
    logic [3:0]  r_code;
    logic [27:0] r_speed;
    logic [2:0]  r_lidx;
    logic [3:0]  r_iidx;
    logic [31:0] r_ival;

    // Walk and apply sequencing.
    logic [tbls_pkg::CNT_W-1:0]  r_lvl;
    logic                        r_rv;
    tbls_pkg::t_level            r_req;
    tbls_pkg::t_level            r_chg;
    logic [tbls_pkg::ITEM_W-1:0] r_k;
    logic                        r_dv;

    // Level table memory.
    logic [31:0] r_mem [tbls_pkg::MEM_DEPTH];
    logic [31:0] r_rdata;
    logic [tbls_pkg::MEM_AW-1:0] w_addr;
    logic        w_we;

    // Output register.
    logic        r_ovalid;
    logic [2:0]  r_ost;
    tbls_pkg::t_level r_olvl;
    logic [3:0]  r_oidx;
    logic [31:0] r_oval;
    logic        r_olast;

    // Decisions.
    logic        w_accept;
    logic        w_out_free;
    logic [3:0]  w_dev4;
    logic [tbls_pkg::DEV_W-1:0] w_dev;
    logic        w_bad;
    logic        w_addr_bad;
    tbls_pkg::t_level w_prev;
    logic [7:0]  w_mask_sh;
    logic        w_slow;
    logic        w_exec_walk;
    logic        w_hit;
    logic        w_walk_done;
    tbls_pkg::t_level w_req_walk;
    logic signed [tbls_pkg::NL_W:0] w_diff;
    logic        w_dec_same;
    logic        w_dec_rel;
    logic        w_dec_skip;
    logic        w_dec_apply;
    tbls_pkg::t_level w_chg;
    logic [tbls_pkg::ITEM_W-1:0] w_k_rd;

    // Result being issued this cycle.
    logic        w_emit;
    logic [2:0]  w_ost;
    tbls_pkg::t_level w_olvl;
    logic [3:0]  w_oidx;
    logic [31:0] w_oval;
    logic        w_olast;

    // Terms used by the checks at the end.
    logic        w_last_emit;
    logic        w_in_apply;
    logic        w_k_ok;
    logic        w_out_applied;

    // ------------------------------------------------------------------
    // Handshake and per-device decode.
    // ------------------------------------------------------------------
    assign o_s_axis_tready = (r_state == tbls_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;

    assign w_dev4     = r_code - 4'd1;
    assign w_dev      = w_dev4[tbls_pkg::DEV_W-1:0];
    assign w_bad      = (r_code == 4'd0) || (r_code > 4'(tbls_pkg::DEVICES))
                        || (r_kind > tbls_pkg::KIND_BLOCK_OFF);
    assign w_addr_bad = (32'(r_lidx) >= 32'(tbls_pkg::LEVELS)) || (r_iidx > tbls_pkg::ITEM_LAST);
    assign w_prev     = r_cur[w_dev];

    // Only the first four devices have a slowdown bit.
    assign w_mask_sh  = {4'b0, r_mask} >> w_dev4;
    assign w_slow     = w_mask_sh[0];

    assign w_exec_walk = !w_bad && (r_kind == tbls_pkg::KIND_REPORT) && !r_blk[w_dev];

    // Threshold walk: the read data belongs to level r_lvl - 1.
    assign w_hit       = r_rv && ({4'b0, r_speed} < r_rdata);
    assign w_walk_done = w_hit || (r_lvl == r_cnt[w_dev]);
    assign w_req_walk  = w_hit ? tbls_pkg::t_level'(r_lvl) - tbls_pkg::t_level'(2)
                               : tbls_pkg::t_level'(r_cnt[w_dev]) - tbls_pkg::t_level'(1);

    // Level change rules.
    assign w_diff      = (tbls_pkg::NL_W+1)'(w_prev) - (tbls_pkg::NL_W+1)'(r_req);
    assign w_dec_same  = (r_req == w_prev);
    assign w_dec_rel   = !w_dec_same && r_req[tbls_pkg::NL_W-1];
    assign w_dec_skip  = !w_dec_same && !w_dec_rel && w_slow && (w_diff == 1);
    assign w_dec_apply = !w_dec_same && !w_dec_rel && !w_dec_skip;
    assign w_chg       = (w_slow && (w_diff > 1)) ? r_req + tbls_pkg::t_level'(1) : r_req;

    // Apply phase reads one item ahead whenever the output moves on.
    assign w_k_rd = (r_dv && w_out_free) ? r_k + 4'd1 : r_k;

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbls_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = tbls_pkg::S_EXEC;
                end
            end
            tbls_pkg::S_EXEC: begin
                if (w_exec_walk) begin
                    n_state = tbls_pkg::S_WALK;
                end else if (w_out_free) begin
                    n_state = tbls_pkg::S_IDLE;
                end
            end
            tbls_pkg::S_WALK: begin
                if (w_walk_done) begin
                    n_state = tbls_pkg::S_DECIDE;
                end
            end
            tbls_pkg::S_DECIDE: begin
                if (w_dec_apply) begin
                    n_state = tbls_pkg::S_APPLY;
                end else if (w_out_free) begin
                    n_state = tbls_pkg::S_IDLE;
                end
            end
            tbls_pkg::S_APPLY: begin
                if (r_dv && w_out_free && (r_k == tbls_pkg::ITEM_LAST)) begin
                    n_state = tbls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tbls_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: result to issue and memory access.
    // ------------------------------------------------------------------
    always_comb begin
        w_emit  = 1'b0;
        w_ost   = tbls_pkg::ST_REJECTED;
        w_olvl  = tbls_pkg::LEVEL_NONE;
        w_oidx  = 4'd0;
        w_oval  = 32'd0;
        w_olast = 1'b1;
        w_we    = 1'b0;
        w_addr  = {w_dev, r_lvl[tbls_pkg::LVL_W-1:0], tbls_pkg::ITEM_THRESH};
        case (r_state)
            tbls_pkg::S_EXEC: begin
                w_emit = w_out_free && !w_exec_walk;
                w_addr = {w_dev, tbls_pkg::LVL_W'(r_lidx), r_iidx};
                if (!w_bad) begin
                    w_olvl = w_prev;
                    case (r_kind)
                        tbls_pkg::KIND_REPORT: begin
                            w_ost = tbls_pkg::ST_UNCHANGED;
                        end
                        tbls_pkg::KIND_TABLE: begin
                            w_ost = w_addr_bad ? tbls_pkg::ST_REJECTED : tbls_pkg::ST_SETUP;
                            w_we  = w_emit && !w_addr_bad;
                        end
                        tbls_pkg::KIND_BLOCK_ON: begin
                            w_ost  = tbls_pkg::ST_RELEASED;
                            w_olvl = tbls_pkg::LEVEL_NONE;
                        end
                        default: begin
                            w_ost = tbls_pkg::ST_SETUP;
                        end
                    endcase
                end
            end
            tbls_pkg::S_DECIDE: begin
                w_emit = w_out_free && !w_dec_apply;
                if (w_dec_rel) begin
                    w_ost  = tbls_pkg::ST_RELEASED;
                    w_olvl = tbls_pkg::LEVEL_NONE;
                end else begin
                    w_ost  = tbls_pkg::ST_UNCHANGED;
                    w_olvl = w_prev;
                end
            end
            tbls_pkg::S_APPLY: begin
                w_emit  = r_dv && w_out_free;
                w_ost   = tbls_pkg::ST_APPLIED;
                w_olvl  = r_chg;
                w_oidx  = r_k;
                w_oval  = r_rdata;
                w_olast = (r_k == tbls_pkg::ITEM_LAST);
                w_addr  = {w_dev, r_chg[tbls_pkg::LVL_W-1:0], w_k_rd};
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Level table: one write or one read a cycle, registered read data.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= r_ival;
        end
        r_rdata <= r_mem[w_addr];
    end

    // ------------------------------------------------------------------
    // Control and per-device state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tbls_pkg::S_IDLE;
            r_mask   <= 4'd0;
            r_ovalid <= 1'b0;
            r_lvl    <= '0;
            r_rv     <= 1'b0;
            r_k      <= tbls_pkg::ITEM_FIRST;
            r_dv     <= 1'b0;
            for (int d = 0; d < tbls_pkg::DEVICES; d++) begin
                r_cnt[d] <= '0;
                r_cur[d] <= tbls_pkg::LEVEL_NONE;
                r_blk[d] <= 1'b0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end

            // Output register holds a result until the sink takes it.
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                tbls_pkg::S_EXEC: begin
                    r_lvl <= '0;
                    r_rv  <= 1'b0;
                    if (w_emit && !w_bad) begin
                        case (r_kind)
                            tbls_pkg::KIND_COUNT: begin
                                r_cnt[w_dev] <= (r_ival > 32'(tbls_pkg::LEVELS))
                                                ? tbls_pkg::CNT_W'(tbls_pkg::LEVELS)
                                                : r_ival[tbls_pkg::CNT_W-1:0];
                            end
                            tbls_pkg::KIND_BLOCK_ON: begin
                                r_blk[w_dev] <= 1'b1;
                                r_cur[w_dev] <= tbls_pkg::LEVEL_NONE;
                            end
                            tbls_pkg::KIND_BLOCK_OFF: begin
                                r_blk[w_dev] <= 1'b0;
                            end
                            default: begin
                                r_blk[w_dev] <= r_blk[w_dev];
                            end
                        endcase
                    end
                end
                tbls_pkg::S_WALK: begin
                    // One threshold read issued per cycle until the count is reached.
                    r_rv <= (r_lvl < r_cnt[w_dev]);
                    if (r_lvl < r_cnt[w_dev]) begin
                        r_lvl <= r_lvl + 1'b1;
                    end
                end
                tbls_pkg::S_DECIDE: begin
                    r_k  <= tbls_pkg::ITEM_FIRST;
                    r_dv <= 1'b0;
                    if (w_dec_apply) begin
                        r_cur[w_dev] <= w_chg;
                    end else if (w_dec_rel && w_emit) begin
                        r_cur[w_dev] <= tbls_pkg::LEVEL_NONE;
                    end
                end
                tbls_pkg::S_APPLY: begin
                    if (!r_dv) begin
                        r_dv <= 1'b1;
                    end else if (w_out_free) begin
                        r_k <= r_k + 4'd1;
                    end
                end
                default: begin
                    r_rv <= 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_s_axis_tuser;
            r_code  <= i_s_axis_tdata[3:0];
            r_speed <= i_s_axis_tdata[31:4];
            r_lidx  <= i_s_axis_tdata[34:32];
            r_iidx  <= i_s_axis_tdata[38:35];
            r_ival  <= i_s_axis_tdata[70:39];
        end
        if ((r_state == tbls_pkg::S_WALK) && w_walk_done) begin
            r_req <= w_req_walk;
        end
        if ((r_state == tbls_pkg::S_DECIDE) && w_dec_apply) begin
            r_chg <= w_chg;
        end
        if (w_emit) begin
            r_ost   <= w_ost;
            r_olvl  <= w_olvl;
            r_oidx  <= w_oidx;
            r_oval  <= w_oval;
            r_olast <= w_olast;
        end
    end

    // Result stream ports.
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_oval, r_oidx, r_olvl};
    assign o_m_axis_tuser  = r_ost;
    assign o_m_axis_tlast  = r_olast;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    assign w_last_emit   = (r_state == tbls_pkg::S_APPLY) && w_emit && w_olast;
    assign w_in_apply    = (r_state == tbls_pkg::S_APPLY);
    assign w_k_ok        = (r_k >= tbls_pkg::ITEM_FIRST) && (r_k <= tbls_pkg::ITEM_LAST);
    assign w_out_applied = r_ovalid && (r_ost == tbls_pkg::ST_APPLIED);

    // The final applied item ends the transaction.
    `TBLS_ASSERT_NEXT(a_apply_end, i_clk, i_rst_n, w_last_emit, r_state == tbls_pkg::S_IDLE)
    // A blocked device never holds a level (checked for device 0).
    `TBLS_ASSERT_NOW(a_block_level, i_clk, i_rst_n, r_blk[0], r_cur[0] == tbls_pkg::LEVEL_NONE)
    // The apply item counter stays within the emitted items.
    `TBLS_ASSERT_NOW(a_item_range, i_clk, i_rst_n, w_in_apply, w_k_ok)
    // Applied results always carry a real level.
    `TBLS_ASSERT_NOW(a_applied_level, i_clk, i_rst_n, w_out_applied, !r_olvl[tbls_pkg::NL_W-1])

endmodule
